### hw/rtl/rc4_pkg.sv
// rc4_pkg: shared constants, register indexes and sequencer states for the rc4 block
// no dependencies; imported by rc4_stream_cipher
`timescale 1ns / 1ps

package rc4_pkg;

	localparam int BYTE_W            = 8;
	localparam int TABLE_DEPTH       = 256;
	localparam int ADDR_W            = $clog2(TABLE_DEPTH);
	localparam int MAX_KEY_BYTES_DEF = 32;
	localparam int KEY_REGS          = 4;
	localparam int KEY_REG_W         = 64;
	localparam int KEY_LEN_W         = 6;
	localparam int CFG_IDX_W         = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN   = 3'd4;

	localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 6'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KS_FILL,
		ST_KS_RD_I,
		ST_KS_RD_J,
		ST_KS_WR_I,
		ST_KS_WR_J,
		ST_GEN_RD_I,
		ST_GEN_RD_J,
		ST_GEN_WR_I,
		ST_GEN_WR_J,
		ST_GEN_OUT
	} rc4_state_t;

endpackage

### hw/rtl/rc4_ram.sv
// rc4_ram: generic single write port, single read port ram with registered read
// a read at the address being written returns the new data; no dependencies
`timescale 1ns / 1ps

module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/rc4_stream_cipher.sv
// rc4_stream_cipher: rc4 byte cipher, key schedule and keystream generator on one table ram
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps
//
//  channel   signals                              dir  word
//  -------   -----------------------------------  ---  ------------------------------------
//  in        in_valid/in_ready, data_byte,        in   one byte to transform, with start
//            message_start                             flag
//  out       out_valid/out_ready, result_byte     out  data byte xor keystream byte
//  cfg       cfg_valid/cfg_ready, cfg_index,      in   key register write (index 0..4),
//            cfg_data                                  other indexes ignored
//
//  a plain byte passes ST_GEN_RD_J, ST_GEN_WR_I, ST_GEN_WR_J and ST_GEN_OUT before its
//  result word is registered, and a new word is taken only in ST_IDLE: each keystream byte
//  needs two table reads, two writes for the swap and a third read through the single
//  read and write ports of the table ram, plus an idle step that takes the next word.
//  a word that starts a message (and the first word after reset) first runs the key
//  schedule: a fill of all 256 entries, a read of S[0], then for each entry a read of
//  S[j] and the two swap writes, plus a step in ST_GEN_RD_I to restart the generator.
//  reset clears indices, keyed flag, output valid and key bytes, sets key length to one;
//  the table itself is not cleared, it is always filled by the key schedule before use.
//  the finished byte waits in the output register; a stalled out channel holds the
//  sequencer in its last step until the register frees up. cfg_ready is always high.

module rc4_stream_cipher
	import rc4_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 message_start,
	// output channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    result_byte,
	// configuration channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_REG_W-1:0] cfg_data
);

	localparam int KIDX_W = $clog2(MAX_KEY_BYTES);
	localparam int ELEN_W = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

	// sequencer and generator state
	rc4_state_t state_q, state_nxt;
	logic [ADDR_W-1:0] i_q;          // generator index i
	logic [ADDR_W-1:0] j_q;          // schedule / generator index j
	logic              keyed_q;      // table holds a keyed permutation
	logic [ADDR_W-1:0] cnt_q;        // schedule entry counter n
	logic [KIDX_W-1:0] kidx_q;       // n mod key length
	logic [BYTE_W-1:0] si_q;         // table value at i (or n)
	logic [BYTE_W-1:0] sj_q;         // table value at j
	logic [BYTE_W-1:0] data_q;       // captured input byte
	logic [BYTE_W-1:0] result_q;
	logic              out_valid_q;

	// key storage
	logic [BYTE_W-1:0]    key_q [MAX_KEY_BYTES];
	logic [KEY_LEN_W-1:0] key_len_q;
	logic [ELEN_W-1:0]    eff_len;
	logic [ELEN_W-1:0]    last_kidx;

	// table ram port signals
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	logic              in_acc;
	logic              cfg_acc;
	logic              out_free;     // output register can take a new byte
	logic              need_ks;      // accepted word must rerun the key schedule
	logic [ADDR_W-1:0] j_ks;         // j + S[n] + key[n mod len]
	logic [ADDR_W-1:0] j_gen;        // j + S[i]
	logic [ADDR_W-1:0] ks_addr;      // S[i] + S[j] after the swap

	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign need_ks   = message_start || !keyed_q;

	assign j_ks    = j_q + ram_rdata + key_q[kidx_q];
	assign j_gen   = j_q + ram_rdata;
	assign ks_addr = si_q + sj_q;

	assign out_valid   = out_valid_q;
	assign result_byte = result_q;

	// key length in use: zero counts as one, clamp to the key storage size
	always_comb begin
		if (key_len_q == '0) begin
			eff_len = ELEN_W'(1);
		end else if (int'(key_len_q) > MAX_KEY_BYTES) begin
			eff_len = ELEN_W'(MAX_KEY_BYTES);
		end else begin
			eff_len = ELEN_W'(key_len_q);
		end
		last_kidx = eff_len - ELEN_W'(1);
	end

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = need_ks ? ST_KS_FILL : ST_GEN_RD_J;
				end
			end
			ST_KS_FILL: begin
				if (cnt_q == LAST_ADDR) begin
					state_nxt = ST_KS_RD_I;
				end
			end
			ST_KS_RD_I:  state_nxt = ST_KS_RD_J;
			ST_KS_RD_J:  state_nxt = ST_KS_WR_I;
			ST_KS_WR_I:  state_nxt = ST_KS_WR_J;
			ST_KS_WR_J: begin
				state_nxt = (cnt_q == LAST_ADDR) ? ST_GEN_RD_I : ST_KS_RD_J;
			end
			ST_GEN_RD_I: state_nxt = ST_GEN_RD_J;
			ST_GEN_RD_J: state_nxt = ST_GEN_WR_I;
			ST_GEN_WR_I: state_nxt = ST_GEN_WR_J;
			ST_GEN_WR_J: state_nxt = ST_GEN_OUT;
			ST_GEN_OUT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// table ram control and input ready
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = si_q;
		ram_raddr = i_q + ADDR_W'(1);
		in_ready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// prefetch S[i+1] so a plain byte skips the first read step
				in_ready  = 1'b1;
				ram_raddr = i_q + ADDR_W'(1);
			end
			ST_KS_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = cnt_q;
			end
			ST_KS_RD_I: begin
				ram_raddr = cnt_q;
			end
			ST_KS_RD_J: begin
				ram_raddr = j_ks;
			end
			ST_KS_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = ram_rdata;
			end
			ST_KS_WR_J: begin
				// write S[j] and fetch S[n+1] in the same cycle
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				ram_raddr = cnt_q + ADDR_W'(1);
			end
			ST_GEN_RD_I: begin
				ram_raddr = i_q + ADDR_W'(1);
			end
			ST_GEN_RD_J: begin
				ram_raddr = j_gen;
			end
			ST_GEN_WR_I: begin
				ram_we    = 1'b1;
				ram_waddr = i_q;
				ram_wdata = ram_rdata;
			end
			ST_GEN_WR_J: begin
				// swap completes here; the keystream read sees the new S[j]
				ram_we    = 1'b1;
				ram_waddr = j_q;
				ram_wdata = si_q;
				ram_raddr = ks_addr;
			end
			ST_GEN_OUT: begin
				ram_raddr = ks_addr;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			keyed_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && need_ks) begin
						j_q <= '0;
					end else if (in_acc) begin
						i_q <= i_q + ADDR_W'(1);
					end
				end
				ST_KS_RD_J:  j_q <= j_ks;
				ST_KS_WR_J: begin
					if (cnt_q == LAST_ADDR) begin
						i_q     <= '0;
						j_q     <= '0;
						keyed_q <= 1'b1;
					end
				end
				ST_GEN_RD_I: i_q <= i_q + ADDR_W'(1);
				ST_GEN_RD_J: j_q <= j_gen;
				default: begin
					j_q <= j_q;
				end
			endcase
			if (state_q == ST_GEN_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					data_q <= data_byte;
					cnt_q  <= '0;
					kidx_q <= '0;
				end
			end
			ST_KS_FILL:  cnt_q <= cnt_q + ADDR_W'(1);
			ST_KS_RD_J:  si_q  <= ram_rdata;
			ST_KS_WR_J: begin
				cnt_q <= cnt_q + ADDR_W'(1);
				if (kidx_q == last_kidx[KIDX_W-1:0]) begin
					kidx_q <= '0;
				end else begin
					kidx_q <= kidx_q + KIDX_W'(1);
				end
			end
			ST_GEN_RD_J: si_q <= ram_rdata;
			ST_GEN_WR_I: sj_q <= ram_rdata;
			ST_GEN_OUT: begin
				if (out_free) begin
					result_q <= data_q ^ ram_rdata;
				end
			end
			default: begin
				si_q <= si_q;
			end
		endcase
	end

	// key registers; each byte sits in the register that holds its group of eight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < MAX_KEY_BYTES; b++) begin
				key_q[b] <= '0;
			end
			key_len_q <= KEY_LEN_RST;
		end else if (cfg_acc) begin
			for (int b = 0; b < MAX_KEY_BYTES; b++) begin
				if (int'(cfg_index) == (b >> 3) && (b >> 3) < KEY_REGS) begin
					key_q[b] <= cfg_data[(b & 7) * BYTE_W +: BYTE_W];
				end
			end
			if (cfg_index == REG_KEY_LEN) begin
				key_len_q <= cfg_data[KEY_LEN_W-1:0];
			end
		end
	end

endmodule
